@@ hw/rtl/mpfd_pkg.sv @@
package mpfd_pkg;

	// command codes
	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_PIXEL  = 3'd1,
		OP_FILL   = 3'd2,
		OP_INVERT = 3'd3,
		OP_HLINE  = 3'd4,
		OP_CHAR   = 3'd5,
		OP_GAUGE  = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	// per-byte update applied by the walker
	typedef enum logic [1:0] {
		MODE_CLR   = 2'd0,
		MODE_SET   = 2'd1,
		MODE_TOG   = 2'd2,
		MODE_GLYPH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		JOB_CLEAR = 2'd0,
		JOB_BOX   = 2'd1,
		JOB_READ  = 2'd2
	} job_kind_t;

	// one walker job: a clipped box, a full wipe or a single byte read
	// for reads, c0 is the column and r0 the page
	typedef struct packed {
		job_kind_t   kind;
		mode_t       mode;
		logic [7:0]  c0;
		logic [8:0]  cw;
		logic [7:0]  r0;
		logic [8:0]  rh;
		logic [6:0]  glyph;
	} job_t;

	localparam logic [7:0] CHAR_FIRST    = 8'h20;
	localparam logic [7:0] CHAR_LAST     = 8'h7E;
	localparam logic [7:0] CHAR_FALLBACK = 8'h3F;
	localparam logic [6:0] LEVEL_MAX     = 7'd127;
	localparam int         GLYPH_COLS    = 5;
	localparam logic [7:0] CHAR_STEP     = 8'd6;
	// floor(p/127) estimate: (p*258)>>15, low by at most one
	localparam logic [8:0] RECIP_127     = 9'd258;

	// 5x8 font, column 0 in the top byte
	localparam logic [39:0] GLYPH_ROM [95] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700,
		40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
		40'h3649552250, 40'h0005030000, 40'h001C224100,
		40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
		40'h4261514946, 40'h2141454B31, 40'h1814127F10,
		40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000,
		40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413E,
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
		40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
		40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
		40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
		40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
		40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204,
		40'h4040404040, 40'h0001020400, 40'h2054545478,
		40'h7F48444438, 40'h3844444420, 40'h384444487F,
		40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
		40'h7C08040478, 40'h3844444438, 40'h7C14141408,
		40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
		40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h00007F0000,
		40'h0041360800, 40'h1008081008
	};

endpackage

@@ hw/rtl/mpfd_ram.sv @@
module mpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/mpfd_walk.sv @@
module mpfd_walk #(
	parameter int COLS  = 128,
	parameter int PAGES = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mpfd_pkg::job_t job,
	output logic          done,
	output logic [7:0]    rd_byte
);

	localparam int DEPTH  = COLS * PAGES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [9:0] COLS_L = 10'(COLS);
	localparam logic [9:0] ROWS_L = 10'(PAGES * 8);

	typedef enum logic [5:0] {
		W_IDLE  = 6'b000001,
		W_CLEAR = 6'b000010,
		W_RD    = 6'b000100,
		W_WR    = 6'b001000,
		W_RDR   = 6'b010000,
		W_RDD   = 6'b100000
	} wstate_t;

	wstate_t              st_q;
	mpfd_pkg::mode_t      mode_q;
	logic [6:0]           glyph_q;
	logic [8:0]           c0_q;
	logic [9:0]           cend_q;
	logic [8:0]           r0_q;
	logic [9:0]           rend_q;
	logic [8:0]           col_q;
	logic [4:0]           page_q;
	logic [4:0]           lastpg_q;
	logic [ADDR_W-1:0]    caddr_q;
	logic                 done_q;
	logic [7:0]           rd_byte_q;

	logic [9:0]           sum_c, sum_r, cend, rend;
	logic                 empty;
	logic [ADDR_W-1:0]    addr;
	logic [7:0]           mask, new_byte, glyph_byte, rdata;
	logic [8:0]           k;
	logic [8:0]           row;
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [7:0]           wdata;

	// clip the job box at start
	always_comb begin
		sum_c = {2'b00, job.c0} + {1'b0, job.cw};
		sum_r = {2'b00, job.r0} + {1'b0, job.rh};
		cend  = (sum_c > COLS_L) ? COLS_L : sum_c;
		rend  = (sum_r > ROWS_L) ? ROWS_L : sum_r;
		empty = (cend <= {2'b00, job.c0}) || (rend <= {2'b00, job.r0});
	end

	assign addr = ADDR_W'(int'(page_q) * COLS + int'(col_q));

	// row mask of the current page
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			row     = {page_q, 3'(i)} + 9'd0;
			mask[i] = ({1'b0, row} >= {1'b0, r0_q}) && ({1'b0, row} < rend_q);
		end
	end

	// glyph column, blank past the fifth
	always_comb begin
		k = col_q - c0_q;
		if (k < 9'(mpfd_pkg::GLYPH_COLS)) begin
			glyph_byte = mpfd_pkg::GLYPH_ROM[glyph_q][8*(4-k[2:0]) +: 8];
		end else begin
			glyph_byte = 8'h00;
		end
	end

	always_comb begin
		case (mode_q)
			mpfd_pkg::MODE_CLR:   new_byte = rdata & ~mask;
			mpfd_pkg::MODE_SET:   new_byte = rdata | mask;
			mpfd_pkg::MODE_TOG:   new_byte = rdata ^ mask;
			default:              new_byte = glyph_byte;
		endcase
	end

	assign we    = (st_q == W_CLEAR) || (st_q == W_WR);
	assign waddr = (st_q == W_CLEAR) ? caddr_q : addr;
	assign wdata = (st_q == W_CLEAR) ? 8'h00 : new_byte;

	mpfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    ((st_q == W_RD) || (st_q == W_RDR)),
		.raddr (addr),
		.rdata (rdata)
	);

	// walk sequencer: one read-modify-write per box byte, a plain write per byte for a wipe, one read for a byte read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= W_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				W_IDLE: begin
					if (start) begin
						unique case (job.kind)
							mpfd_pkg::JOB_CLEAR: st_q <= W_CLEAR;
							mpfd_pkg::JOB_READ:  st_q <= W_RDR;
							default: begin
								if (empty) begin
									done_q <= 1'b1;
								end else begin
									st_q <= W_RD;
								end
							end
						endcase
					end
				end
				W_CLEAR: begin
					if (caddr_q == ADDR_W'(DEPTH - 1)) begin
						st_q   <= W_IDLE;
						done_q <= 1'b1;
					end
				end
				W_RD: st_q <= W_WR;
				W_WR: begin
					if ({1'b0, col_q} + 10'd1 < cend_q) begin
						st_q <= W_RD;
					end else if (page_q != lastpg_q) begin
						st_q <= W_RD;
					end else begin
						st_q   <= W_IDLE;
						done_q <= 1'b1;
					end
				end
				W_RDR: st_q <= W_RDD;
				W_RDD: begin
					st_q   <= W_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= W_IDLE;
			endcase
		end
	end

	// walk counters and job registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caddr_q <= '0;
		end else begin
			if (st_q == W_IDLE && start) begin
				caddr_q  <= '0;
				mode_q   <= job.mode;
				glyph_q  <= job.glyph;
				c0_q     <= {1'b0, job.c0};
				r0_q     <= {1'b0, job.r0};
				cend_q   <= cend;
				rend_q   <= rend;
				lastpg_q <= 5'((rend - 10'd1) >> 3);
				col_q    <= {1'b0, job.c0};
				if (job.kind == mpfd_pkg::JOB_READ) begin
					page_q <= job.r0[4:0];
				end else begin
					page_q <= job.r0[7:3];
				end
			end
			if (st_q == W_CLEAR) begin
				caddr_q <= caddr_q + ADDR_W'(1);
			end
			if (st_q == W_WR) begin
				if ({1'b0, col_q} + 10'd1 < cend_q) begin
					col_q <= col_q + 9'd1;
				end else begin
					col_q  <= c0_q;
					page_q <= page_q + 5'd1;
				end
			end
			if (st_q == W_RDD) begin
				rd_byte_q <= rdata;
			end
		end
	end

	assign done    = done_q;
	assign rd_byte = rd_byte_q;

endmodule

@@ hw/rtl/mono_page_framebuffer_draw.sv @@
// Pixel/box/line/gauge commands do one read-modify-write per touched store byte on the
// frame store; a full clear writes zero to every store byte and a read fetches one byte.
// Throughput: one command at a time; s_tready is high only when the engine is idle.
// Reset: after arst_n releases, a clearing pass writes zero to all
// SCREEN_COLUMNS*SCREEN_PAGES bytes (1024 by default) before commands are taken.
module mono_page_framebuffer_draw #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_PAGES   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[2:0], x_pos[10:3], y_pos[18:11], page_index[26:19], rect_width[34:27],
	// rect_height[42:35], pixel_on[43], char_code[51:44], gauge_level[59:52], zero
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[7:0], next_x[15:8]
	output logic [15:0] m_tdata
);

	localparam logic [8:0] COLS_W = 9'(SCREEN_COLUMNS);
	localparam logic [8:0] PGS_W  = 9'(SCREEN_PAGES);

	typedef enum logic [9:0] {
		S_INIT  = 10'b0000000001,
		S_INITW = 10'b0000000010,
		S_IDLE  = 10'b0000000100,
		S_CMD   = 10'b0000001000,
		S_WAIT  = 10'b0000010000,
		S_MUL   = 10'b0000100000,
		S_QEST  = 10'b0001000000,
		S_QFIX  = 10'b0010000000,
		S_GBOX  = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t        st_q;
	mpfd_pkg::op_t op_q;
	logic [7:0]    x_q, y_q, page_q, w_q, h_q, code_q, level_q;
	logic          on_q;
	logic [2:0]    gidx_q;
	logic [14:0]   prod_q;
	logic [7:0]    qest_q, fillw_q;
	logic [15:0]   m_tdata_q;
	logic          m_tvalid_q;

	logic            start, done;
	mpfd_pkg::job_t  job;
	logic [7:0]      walk_rd;
	logic            page_ok, read_ok, char_ok;
	logic [6:0]      lvl;
	logic [7:0]      glyph_code;
	logic [23:0]     qprod;
	logic [14:0]     qrem;
	logic [7:0]      rd_val, nx_val;
	logic            accept;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (st_q == S_IDLE);

	assign page_ok = {1'b0, page_q} < PGS_W;
	assign read_ok = page_ok && ({1'b0, x_q} < COLS_W);
	assign char_ok = (code_q >= mpfd_pkg::CHAR_FIRST) && (code_q <= mpfd_pkg::CHAR_LAST);
	assign glyph_code = (char_ok ? code_q : mpfd_pkg::CHAR_FALLBACK) - mpfd_pkg::CHAR_FIRST;
	assign lvl   = (level_q > {1'b0, mpfd_pkg::LEVEL_MAX}) ? mpfd_pkg::LEVEL_MAX : level_q[6:0];
	assign qprod = {9'd0, prod_q} * {15'd0, mpfd_pkg::RECIP_127};
	assign qrem  = prod_q - ({qest_q, 7'd0} - {7'd0, qest_q});

	// job for the walker
	always_comb begin
		job       = '0;
		job.kind  = mpfd_pkg::JOB_BOX;
		job.mode  = mpfd_pkg::MODE_SET;
		job.glyph = glyph_code[6:0];
		start     = 1'b0;
		if (st_q == S_INIT) begin
			job.kind = mpfd_pkg::JOB_CLEAR;
			start    = 1'b1;
		end else if (st_q == S_CMD) begin
			case (op_q)
				mpfd_pkg::OP_CLEAR: begin
					job.kind = mpfd_pkg::JOB_CLEAR;
					start    = 1'b1;
				end
				mpfd_pkg::OP_PIXEL: begin
					job.mode = on_q ? mpfd_pkg::MODE_SET : mpfd_pkg::MODE_CLR;
					job.c0 = x_q; job.cw = 9'd1; job.r0 = y_q; job.rh = 9'd1;
					start  = 1'b1;
				end
				mpfd_pkg::OP_FILL, mpfd_pkg::OP_INVERT: begin
					if (op_q == mpfd_pkg::OP_INVERT) begin
						job.mode = mpfd_pkg::MODE_TOG;
					end else begin
						job.mode = on_q ? mpfd_pkg::MODE_SET : mpfd_pkg::MODE_CLR;
					end
					job.c0 = x_q; job.cw = {1'b0, w_q}; job.r0 = y_q; job.rh = {1'b0, h_q};
					start  = 1'b1;
				end
				mpfd_pkg::OP_HLINE: begin
					job.c0 = 8'd0; job.cw = COLS_W; job.r0 = y_q; job.rh = 9'd1;
					start  = 1'b1;
				end
				mpfd_pkg::OP_CHAR: begin
					job.mode = mpfd_pkg::MODE_GLYPH;
					job.c0 = x_q; job.cw = 9'(mpfd_pkg::CHAR_STEP);
					job.r0 = {page_q[4:0], 3'd0}; job.rh = 9'd8;
					start  = page_ok;
				end
				mpfd_pkg::OP_READ: begin
					job.kind = mpfd_pkg::JOB_READ;
					job.c0 = x_q; job.r0 = page_q;
					start  = read_ok;
				end
				default: start = 1'b0;
			endcase
		end else if (st_q == S_GBOX) begin
			start = 1'b1;
			case (gidx_q)
				3'd0: begin
					job.c0 = x_q; job.cw = {1'b0, w_q}; job.r0 = y_q; job.rh = 9'd1;
				end
				3'd1: begin
					job.c0 = x_q; job.cw = {1'b0, w_q};
					job.r0 = y_q + h_q - 8'd1; job.rh = 9'd1;
				end
				3'd2: begin
					job.c0 = x_q; job.cw = 9'd1; job.r0 = y_q; job.rh = {1'b0, h_q};
				end
				3'd3: begin
					job.c0 = x_q + w_q - 8'd1; job.cw = 9'd1;
					job.r0 = y_q; job.rh = {1'b0, h_q};
				end
				default: begin
					job.c0 = x_q + 8'd1; job.cw = {1'b0, fillw_q};
					job.r0 = y_q + 8'd1; job.rh = {1'b0, h_q - 8'd2};
				end
			endcase
		end
	end

	mpfd_walk #(.COLS(SCREEN_COLUMNS), .PAGES(SCREEN_PAGES)) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.job     (job),
		.done    (done),
		.rd_byte (walk_rd)
	);

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_INIT;
			gidx_q <= '0;
		end else begin
			unique case (st_q)
				S_INIT:  st_q <= S_INITW;
				S_INITW: if (done) st_q <= S_IDLE;
				S_IDLE:  if (accept) st_q <= S_CMD;
				S_CMD: begin
					case (op_q)
						mpfd_pkg::OP_CHAR:  st_q <= page_ok ? S_WAIT : S_DONE;
						mpfd_pkg::OP_READ:  st_q <= read_ok ? S_WAIT : S_DONE;
						mpfd_pkg::OP_GAUGE: begin
							gidx_q <= '0;
							st_q   <= (w_q < 8'd2 || h_q < 8'd2) ? S_DONE : S_MUL;
						end
						default: st_q <= S_WAIT;
					endcase
				end
				S_MUL:  st_q <= S_QEST;
				S_QEST: st_q <= S_QFIX;
				S_QFIX: st_q <= S_GBOX;
				S_GBOX: st_q <= S_WAIT;
				S_WAIT: begin
					if (done) begin
						if (op_q == mpfd_pkg::OP_GAUGE && gidx_q != 3'd4) begin
							gidx_q <= gidx_q + 3'd1;
							st_q   <= S_GBOX;
						end else begin
							st_q <= S_DONE;
						end
					end
				end
				S_DONE: if (!m_tvalid_q || m_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// command fields and gauge fill width
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= mpfd_pkg::op_t'(s_tdata[2:0]);
			x_q     <= s_tdata[10:3];
			y_q     <= s_tdata[18:11];
			page_q  <= s_tdata[26:19];
			w_q     <= s_tdata[34:27];
			h_q     <= s_tdata[42:35];
			on_q    <= s_tdata[43];
			code_q  <= s_tdata[51:44];
			level_q <= s_tdata[59:52];
		end
		if (st_q == S_MUL) begin
			prod_q <= {8'd0, lvl} * {7'd0, w_q - 8'd2};
		end
		if (st_q == S_QEST) begin
			qest_q <= qprod[22:15];
		end
		if (st_q == S_QFIX) begin
			fillw_q <= qest_q + ((qrem >= 15'd127) ? 8'd1 : 8'd0);
		end
	end

	assign rd_val = (op_q == mpfd_pkg::OP_READ && read_ok) ? walk_rd : 8'd0;
	assign nx_val = (op_q == mpfd_pkg::OP_CHAR) ?
		(page_ok ? x_q + mpfd_pkg::CHAR_STEP : x_q) : 8'd0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (st_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {nx_val, rd_val};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int COLS      = 128;
	localparam int PAGES     = 8;
	localparam int ROWS      = PAGES * 8;
	localparam int WDOG_MAX  = 20000;
	localparam int HOLD_LONG = 400;

	// touch modes of the predictor
	localparam int PM_CLR = 0;
	localparam int PM_SET = 1;
	localparam int PM_TOG = 2;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	mono_page_framebuffer_draw dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// 5x8 font, column 0 in bits 39:32
	logic [39:0] font_cols [95] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
		40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
		40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
		40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
		40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
		40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
	};

	// shadow of the frame store and results still owed by the block
	logic [7:0]  shadow_fb [COLS*PAGES];
	logic [15:0] owed_beats [$];

	int  err_cnt;
	bit  idle_on;
	bit  hold_req;
	int  hold_cnt;
	int  rx_wait;
	int  wdog;

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic void px_touch(int unsigned c, int unsigned r, int mode);
		int unsigned idx;
		logic [7:0] bm;
		if (c >= COLS || r >= ROWS) return;
		idx = (r >> 3) * COLS + c;
		bm  = 8'd1 << (r & 7);
		if (mode == PM_CLR) shadow_fb[idx] = shadow_fb[idx] & ~bm;
		else if (mode == PM_SET) shadow_fb[idx] = shadow_fb[idx] | bm;
		else shadow_fb[idx] = shadow_fb[idx] ^ bm;
	endfunction

	function automatic void box_touch(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h, int mode);
		int unsigned r_end, c_end;
		r_end = (y + h > ROWS) ? ROWS : y + h;
		c_end = (x + w > COLS) ? COLS : x + w;
		for (int unsigned r = y; r < r_end; r++)
			for (int unsigned c = x; c < c_end; c++)
				px_touch(c, r, mode);
	endfunction

	function automatic logic [7:0] glyph_draw(int unsigned x, int unsigned pg,
			int unsigned code);
		int unsigned gi, base;
		if (pg >= PAGES) return x[7:0];
		if (code < 'h20 || code > 'h7E) code = 'h3F;
		gi   = code - 'h20;
		base = pg * COLS;
		for (int unsigned k = 0; k < 5; k++)
			if (x + k < COLS) shadow_fb[base + x + k] = font_cols[gi][39 - 8*k -: 8];
		if (x + 5 < COLS) shadow_fb[base + x + 5] = 8'h00;
		return (x + 6) & 8'hFF;
	endfunction

	function automatic void gauge_draw(int unsigned x, int unsigned y, int unsigned w,
			int unsigned h, int unsigned v);
		int unsigned bot, rgt, lim, fw;
		if (w < 2 || h < 2) return;
		if (v > 127) v = 127;
		bot = (y + h - 1) & 'hFF;
		rgt = (x + w - 1) & 'hFF;
		lim = (x + w > COLS) ? COLS : x + w;
		for (int unsigned i = x; i < lim; i++) begin
			px_touch(i, y, PM_SET);
			px_touch(i, bot, PM_SET);
		end
		lim = (y + h > ROWS) ? ROWS : y + h;
		for (int unsigned i = y; i < lim; i++) begin
			px_touch(x, i, PM_SET);
			px_touch(rgt, i, PM_SET);
		end
		fw = (v * (w - 2)) / 127;
		box_touch((x + 1) & 'hFF, (y + 1) & 'hFF, fw, h - 2, PM_SET);
	endfunction

	// apply one command to the shadow store, return {next_x, read_data}
	function automatic logic [15:0] draw_cmd(logic [63:0] d);
		mpfd_pkg::op_t op;
		int unsigned x, y, pg, w, h, on, cc, lv;
		logic [7:0] rd, nx;
		op = mpfd_pkg::op_t'(d[2:0]);
		x  = d[10:3];  y  = d[18:11]; pg = d[26:19]; w = d[34:27];
		h  = d[42:35]; on = d[43];    cc = d[51:44]; lv = d[59:52];
		rd = 8'h00; nx = 8'h00;
		case (op)
			mpfd_pkg::OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
			mpfd_pkg::OP_PIXEL: px_touch(x, y, on ? PM_SET : PM_CLR);
			mpfd_pkg::OP_FILL: box_touch(x, y, w, h, on ? PM_SET : PM_CLR);
			mpfd_pkg::OP_INVERT: box_touch(x, y, w, h, PM_TOG);
			mpfd_pkg::OP_HLINE: if (y < ROWS) box_touch(0, y, COLS, 1, PM_SET);
			mpfd_pkg::OP_CHAR: nx = glyph_draw(x, pg, cc);
			mpfd_pkg::OP_GAUGE: gauge_draw(x, y, w, h, lv);
			default: if (pg < PAGES && x < COLS) rd = shadow_fb[pg * COLS + x];
		endcase
		return {nx, rd};
	endfunction

	// ---------------- sender ----------------
	task automatic send_cmd(mpfd_pkg::op_t op, int x, int y, int pg, int w, int h, int on,
			int cc, int lv);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, lv[7:0], cc[7:0], on[0], h[7:0], w[7:0], pg[7:0], y[7:0],
			x[7:0], op};
		do @(posedge clk); while (!s_tready);
		owed_beats.push_back(draw_cmd(s_tdata));
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (owed_beats.size() != 0) @(posedge clk);
	endtask

	// ---------------- result checker and receiver pacing ----------------
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (owed_beats.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected beat: got %h", m_tdata);
				end else begin
					want = owed_beats.pop_front();
					if (m_tdata[7:0] !== want[7:0] || m_tdata[15:8] !== want[15:8]) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: read_data exp %h got %h, next_x exp %h got %h",
								want[7:0], m_tdata[7:0], want[15:8], m_tdata[15:8]);
					end
				end
				rx_wait = idle_on ? $urandom_range(0, 4) : 0;
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_LONG;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog: cycles without any beat on either side, not counted during a receiver hold
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_cnt > 0)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------- tests ----------------
	task automatic test_pixels();
		send_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0);
		send_cmd(mpfd_pkg::OP_PIXEL, 127, 63, 0, 0, 0, 1, 0, 0);
		send_cmd(mpfd_pkg::OP_PIXEL, 128, 0, 0, 0, 0, 1, 0, 0);
		send_cmd(mpfd_pkg::OP_PIXEL, 0, 64, 0, 0, 0, 1, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 127, 0, 7, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 255, 0, 255, 0, 0, 0, 255, 255);
	endtask

	task automatic test_boxes();
		send_cmd(mpfd_pkg::OP_FILL, 0, 0, 0, 255, 255, 1, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 64, 0, 3, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_INVERT, 3, 5, 0, 0, 9, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_INVERT, 120, 60, 0, 255, 255, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 125, 0, 7, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_HLINE, 0, 63, 0, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_HLINE, 0, 64, 0, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 50, 0, 7, 0, 0, 0, 0, 0);
	endtask

	task automatic test_chars();
		send_cmd(mpfd_pkg::OP_CHAR, 0, 0, 0, 0, 0, 0, 'h41, 0);
		send_cmd(mpfd_pkg::OP_CHAR, 124, 0, 7, 0, 0, 0, 'h7E, 0);
		send_cmd(mpfd_pkg::OP_CHAR, 253, 0, 2, 0, 0, 0, 'h20, 0);
		send_cmd(mpfd_pkg::OP_CHAR, 10, 0, 8, 0, 0, 0, 'h41, 0);
		send_cmd(mpfd_pkg::OP_CHAR, 30, 0, 1, 0, 0, 0, 'h1F, 0);
		send_cmd(mpfd_pkg::OP_CHAR, 40, 0, 1, 0, 0, 0, 'hFF, 0);
		send_cmd(mpfd_pkg::OP_READ, 125, 0, 7, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 32, 0, 1, 0, 0, 0, 0, 0);
	endtask

	task automatic test_gauges();
		send_cmd(mpfd_pkg::OP_GAUGE, 5, 5, 0, 1, 10, 0, 0, 100);
		send_cmd(mpfd_pkg::OP_GAUGE, 10, 20, 0, 20, 10, 0, 0, 255);
		send_cmd(mpfd_pkg::OP_GAUGE, 60, 40, 0, 30, 8, 0, 0, 64);
		send_cmd(mpfd_pkg::OP_GAUGE, 250, 250, 0, 10, 10, 0, 0, 127);
		send_cmd(mpfd_pkg::OP_GAUGE, 120, 60, 0, 200, 200, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 15, 0, 3, 0, 0, 0, 0, 0);
		send_cmd(mpfd_pkg::OP_READ, 122, 0, 7, 0, 0, 0, 0, 0);
	endtask

	function automatic int pick_coord(int vis);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, vis);
	endfunction

	function automatic int pick_size();
		return ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
	endfunction

	task automatic send_random();
		int sel;
		mpfd_pkg::op_t op;
		sel = $urandom_range(0, 99);
		if (sel < 2) op = mpfd_pkg::OP_CLEAR;
		else if (sel < 30) op = mpfd_pkg::OP_READ;
		else op = mpfd_pkg::op_t'($urandom_range(1, 6));
		send_cmd(op, pick_coord(COLS - 1), pick_coord(ROWS - 1),
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8),
			pick_size(), pick_size(), $urandom_range(0, 1), $urandom_range(0, 255),
			$urandom_range(0, 255));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
			send_random();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++) send_random();
		wait_drained();
		for (int i = 0; i < 6; i++) send_random();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		err_cnt  = 0;
		idle_on  = 1'b1;
		hold_req = 1'b0;
		hold_cnt = 0;
		rx_wait  = 0;
		wdog     = 0;
		foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_pixels();
		test_boxes();
		test_chars();
		test_gauges();
		test_backpressure();
		test_random(550);
		wait_drained();
		repeat (50) @(posedge clk);

		if (err_cnt == 0 && owed_beats.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/mpfd_pkg.sv
hw/rtl/mpfd_ram.sv
hw/rtl/mpfd_walk.sv
hw/rtl/mono_page_framebuffer_draw.sv
tb/sv/testbench.sv
